@@ rtl/tsd_pkg.sv @@
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types, constants and the arctangent table for the slant delay unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tsd_pkg;

  localparam int SQRT_STEPS    = 26;
  localparam int CORDIC_STAGES = 24;
  localparam int DIV_STEPS     = 22;
  // squares, sum, root steps, fold, rotations, divide setup, divide steps,
  // mapping, products, output
  localparam int LATENCY = 2 + SQRT_STEPS + 1 + CORDIC_STAGES + 1 + DIV_STEPS + 3;

  localparam logic [25:0] HALF_PI_Q24 = 26'd26353589;
  localparam logic [25:0] PI_Q24      = 26'd52707179;
  localparam logic [33:0] GAIN_Q30    = 34'd652032874;
  localparam logic [21:0] MAP_MAX     = 22'h3FFFFF;
  localparam logic [23:0] DELAY_MAX   = 24'hFFFFFF;
  localparam logic [33:0] SAT_LIMIT   = 34'd16777216;
  localparam logic [46:0] DIV_NUM     = 47'h400000000000;

  localparam logic [1:0] REG_DRY_ZD  = 2'd0;
  localparam logic [1:0] REG_WET_ZD  = 2'd1;
  localparam logic [1:0] REG_DRY_OFF = 2'd2;
  localparam logic [1:0] REG_WET_OFF = 2'd3;

  typedef struct packed {
    logic [52:0] rem;
    logic [25:0] root;
  } sqrt_lane_t;

  typedef struct packed {
    logic [33:0] x;
    logic [33:0] y;
    logic [33:0] z;
  } cordic_lane_t;

  typedef struct packed {
    logic [31:0] s;
    logic [46:0] rem;
    logic [21:0] q;
    logic        sat;
  } div_lane_t;

  function automatic logic [33:0] atan_q30(input logic [4:0] i);
    logic [33:0] a;
    case (i)
      5'd0:  a = 34'h3243F6A8;
      5'd1:  a = 34'h1DAC6705;
      5'd2:  a = 34'h0FADBAFC;
      5'd3:  a = 34'h07F56EA6;
      5'd4:  a = 34'h03FEAB76;
      5'd5:  a = 34'h01FFD55B;
      5'd6:  a = 34'h00FFFAAA;
      5'd7:  a = 34'h007FFF55;
      5'd8:  a = 34'h003FFFEA;
      5'd9:  a = 34'h001FFFFD;
      5'd10: a = 34'h000FFFFF;
      5'd11: a = 34'h0007FFFF;
      5'd12: a = 34'h0003FFFF;
      5'd13: a = 34'h0001FFFF;
      5'd14: a = 34'h0000FFFF;
      5'd15: a = 34'h00007FFF;
      5'd16: a = 34'h00003FFF;
      5'd17: a = 34'h00001FFF;
      5'd18: a = 34'h00000FFF;
      5'd19: a = 34'h000007FF;
      5'd20: a = 34'h000003FF;
      5'd21: a = 34'h000001FF;
      5'd22: a = 34'h000000FF;
      5'd23: a = 34'h0000007F;
      5'd24: a = 34'h0000003F;
      5'd25: a = 34'h0000001F;
      5'd26: a = 34'h0000000F;
      5'd27: a = 34'h00000008;
      5'd28: a = 34'h00000004;
      5'd29: a = 34'h00000002;
      5'd30: a = 34'h00000001;
      default: a = 34'h0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ rtl/tsd_if.sv @@
// ----------------------------------------------------------------------------
// tsd_in_if / tsd_out_if
// Valid/ready channels for elevation beats and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface tsd_in_if;
  logic        valid;
  logic        ready;
  logic [24:0] elevation;
  modport source (output valid, output elevation, input ready);
  modport sink (input valid, input elevation, output ready);
endinterface

interface tsd_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] slant_delay;
  logic [21:0] dry_mapping;
  logic [21:0] wet_mapping;
  modport source (output valid, output slant_delay, output dry_mapping,
                  output wet_mapping, input ready);
  modport sink (input valid, input slant_delay, input dry_mapping,
                input wet_mapping, output ready);
endinterface
`default_nettype wire

@@ rtl/tsd_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// tsd_sqrt_cell
// One bit of the exact integer square root, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tsd_sqrt_cell (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [4:0]          k,
  input  wire tsd_pkg::sqrt_lane_t d_in,
  output tsd_pkg::sqrt_lane_t      d_out
);
  logic [52:0]         term;
  tsd_pkg::sqrt_lane_t lane_nxt;

  always_comb begin
    // (root + 2^k)^2 - root^2
    term = ({27'b0, d_in.root} << ({1'b0, k} + 6'd1)) | (53'd1 << {k, 1'b0});
    lane_nxt = d_in;
    if (d_in.rem >= term) begin
      lane_nxt.rem  = d_in.rem - term;
      lane_nxt.root = d_in.root | (26'd1 << k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= lane_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/tsd_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// tsd_cordic_cell
// One rotation-mode micro-rotation, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tsd_cordic_cell (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [4:0]            idx,
  input  wire tsd_pkg::cordic_lane_t d_in,
  output tsd_pkg::cordic_lane_t      d_out
);
  logic signed [33:0]    xs, ys;
  tsd_pkg::cordic_lane_t lane_nxt;

  always_comb begin
    xs = $signed(d_in.x) >>> idx;
    ys = $signed(d_in.y) >>> idx;
    if (!d_in.z[33]) begin
      lane_nxt.x = d_in.x - ys;
      lane_nxt.y = d_in.y + xs;
      lane_nxt.z = d_in.z - tsd_pkg::atan_q30(idx);
    end else begin
      lane_nxt.x = d_in.x + ys;
      lane_nxt.y = d_in.y - xs;
      lane_nxt.z = d_in.z + tsd_pkg::atan_q30(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= lane_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/tsd_div_cell.sv @@
// ----------------------------------------------------------------------------
// tsd_div_cell
// One quotient bit of the restoring reciprocal divide, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tsd_div_cell (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [4:0]         k,
  input  wire tsd_pkg::div_lane_t d_in,
  output tsd_pkg::div_lane_t      d_out
);
  logic [53:0]        dsh;
  logic [53:0]        remx;
  logic [53:0]        diff;
  tsd_pkg::div_lane_t lane_nxt;

  always_comb begin
    dsh  = {22'b0, d_in.s} << k;
    remx = {7'b0, d_in.rem};
    diff = remx - dsh;
    lane_nxt = d_in;
    if (remx >= dsh) begin
      lane_nxt.rem = diff[46:0];
      lane_nxt.q   = d_in.q | (22'd1 << k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= lane_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/tropo_slant_delay_unit.sv @@
// ----------------------------------------------------------------------------
// tropo_slant_delay_unit
// Dry and wet elevation mappings and total slant delay, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | handshake
//  in_ch    | in  | elevation[24:0]                           | valid/ready
//  out_ch   | out | slant_delay[23:0], dry/wet_mapping[21:0]  | valid/ready
//  cfg      | in  | cfg_index[1:0], cfg_wdata[21:0]           | cfg_we
//
// one beat per cycle while no result waits; 26 root cells, 24 rotation
// cells and 22 divide cells per lane, plus setup and product stages
// the whole pipeline moves together and holds while a result waits
// sync active-low reset clears the valid chain and loads default registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tropo_slant_delay_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tsd_in_if.sink           in_ch,
  tsd_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [21:0] cfg_wdata
);
  localparam int LAT = tsd_pkg::LATENCY;
  localparam int NSQ = tsd_pkg::SQRT_STEPS;
  localparam int NCR = tsd_pkg::CORDIC_STAGES;
  localparam int NDV = tsd_pkg::DIV_STEPS;

  logic [17:0] dry_zd_r, wet_zd_r;
  logic [21:0] dry_off_r, wet_off_r;
  logic [LAT-1:0] vld_r;
  logic adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dry_zd_r  <= 18'd150881;
      wet_zd_r  <= 18'd6605;
      dry_off_r <= 22'd732044;
      wet_off_r <= 22'd439226;
    end else if (cfg_we) begin
      case (cfg_index)
        tsd_pkg::REG_DRY_ZD:  dry_zd_r  <= cfg_wdata[17:0];
        tsd_pkg::REG_WET_ZD:  wet_zd_r  <= cfg_wdata[17:0];
        tsd_pkg::REG_DRY_OFF: dry_off_r <= cfg_wdata;
        tsd_pkg::REG_WET_OFF: wet_off_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // squares, then sums
  logic [49:0] esq_r;
  logic [43:0] osq_r [2];
  logic [21:0] off [2];
  assign off[0] = dry_off_r;
  assign off[1] = wet_off_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      esq_r    <= in_ch.elevation * in_ch.elevation;
      osq_r[0] <= off[0] * off[0];
      osq_r[1] <= off[1] * off[1];
    end
  end

  tsd_pkg::sqrt_lane_t   sq   [2][NSQ+1];
  tsd_pkg::cordic_lane_t cr   [2][NCR+1];
  tsd_pkg::div_lane_t    dv   [2][NDV+1];
  logic [21:0]           map_r [2];
  logic [39:0]           prod_r [2];
  logic [21:0]           mapd_r [2];
  logic [17:0]           zd [2];
  assign zd[0] = dry_zd_r;
  assign zd[1] = wet_zd_r;

  genvar ln, j;
  generate
    for (ln = 0; ln < 2; ln++) begin : g_lane
      logic [25:0] ang;
      logic [25:0] root;
      assign root = sq[ln][NSQ].root;
      assign ang  = (root > tsd_pkg::HALF_PI_Q24) ? (tsd_pkg::PI_Q24 - root) : root;

      always_ff @(posedge clk) begin
        if (adv) begin
          sq[ln][0].rem  <= {3'b0, esq_r} + {9'b0, osq_r[ln]};
          sq[ln][0].root <= '0;
          cr[ln][0].x    <= tsd_pkg::GAIN_Q30;
          cr[ln][0].y    <= '0;
          cr[ln][0].z    <= {2'b0, ang, 6'b0};
          // tiny or negative sine saturates the reciprocal
          dv[ln][0].sat  <= $signed(cr[ln][NCR].y) <= $signed(tsd_pkg::SAT_LIMIT);
          dv[ln][0].s    <= cr[ln][NCR].y[31:0];
          dv[ln][0].rem  <= tsd_pkg::DIV_NUM;
          dv[ln][0].q    <= '0;
          map_r[ln]      <= dv[ln][NDV].sat ? tsd_pkg::MAP_MAX : dv[ln][NDV].q;
          prod_r[ln]     <= zd[ln] * map_r[ln];
          mapd_r[ln]     <= map_r[ln];
        end
      end

      for (j = 0; j < NSQ; j++) begin : g_sq
        tsd_sqrt_cell u_cell (
          .clk(clk), .en(adv), .k(5'(NSQ - 1 - j)),
          .d_in(sq[ln][j]), .d_out(sq[ln][j+1])
        );
      end
      for (j = 0; j < NCR; j++) begin : g_cr
        tsd_cordic_cell u_cell (
          .clk(clk), .en(adv), .idx(5'(j)),
          .d_in(cr[ln][j]), .d_out(cr[ln][j+1])
        );
      end
      for (j = 0; j < NDV; j++) begin : g_dv
        tsd_div_cell u_cell (
          .clk(clk), .en(adv), .k(5'(NDV - 1 - j)),
          .d_in(dv[ln][j]), .d_out(dv[ln][j+1])
        );
      end
    end
  endgenerate

  logic [40:0] sum;
  logic [24:0] sum_sh;
  logic [23:0] slant_r;
  logic [21:0] dm_r, wm_r;
  assign sum    = {1'b0, prod_r[0]} + {1'b0, prod_r[1]};
  assign sum_sh = sum[40:16];

  always_ff @(posedge clk) begin
    if (adv) begin
      slant_r <= sum_sh[24] ? tsd_pkg::DELAY_MAX : sum_sh[23:0];
      dm_r    <= mapd_r[0];
      wm_r    <= mapd_r[1];
    end
  end

  assign out_ch.valid       = vld_r[LAT-1];
  assign out_ch.slant_delay = slant_r;
  assign out_ch.dry_mapping = dm_r;
  assign out_ch.wet_mapping = wm_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r)) else $error("valid chain moved during stall");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    adv && dv[0][NDV].sat |=> map_r[0] == tsd_pkg::MAP_MAX)
    else $error("saturated dry mapping lost");
  a_rst: assert property (@(posedge clk)
    $past(!rst_n) |-> vld_r == '0) else $error("valid chain not cleared");
endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tropospheric slant delay unit. A built-in
// predictor covers the root, rotation and divide arithmetic and checks every
// result beat in order. Both channels idle and stall at random, and the
// four delay and offset registers are swept through several settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [23:0] slant_delay;
    logic [21:0] dry_mapping;
    logic [21:0] wet_mapping;
  } delay_result_t;

  typedef struct {
    logic [24:0]   elevation;
    bit            typed;
    delay_result_t known;
  } elev_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [21:0] cfg_wdata;

  tsd_in_if in_ch ();
  tsd_out_if out_ch ();

  tropo_slant_delay_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // local copy of the registers
  logic [17:0] dry_zd, wet_zd;
  logic [21:0] dry_off, wet_off;

  delay_result_t expected_results[$];
  int errors, beats_sent, beats_checked, settings_run;
  bit quiet;          // no idling on either side
  int hold_cycles;    // long receiver hold-off request

  localparam longint ATAN_TAB [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint cordic_sine(input longint ang);
    longint x, y, z, nx;
    x = 652032874;
    y = 0;
    if (ang > 26353589) ang = 52707179 - ang;  // fold past a right angle
    z = ang * 64;
    for (int i = 0; i < tsd_pkg::CORDIC_STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_TAB[i];
      end
      x = nx;
    end
    return y;
  endfunction

  function automatic logic [21:0] mapping_factor(input logic [24:0] e, input logic [21:0] off);
    longint unsigned a, m;
    longint s;
    a = int_root(longint'(e) * longint'(e) + longint'(off) * longint'(off));
    s = cordic_sine(longint'(a));
    if (s <= 0) return tsd_pkg::MAP_MAX;
    m = (64'd1 << 46) / longint'(s);
    return (m > 64'd4194303) ? tsd_pkg::MAP_MAX : m[21:0];
  endfunction

  function automatic delay_result_t predict_delay(input logic [24:0] e);
    delay_result_t r;
    longint unsigned d;
    r.dry_mapping = mapping_factor(e, dry_off);
    r.wet_mapping = mapping_factor(e, wet_off);
    d = (longint'(dry_zd) * r.dry_mapping + longint'(wet_zd) * r.wet_mapping) >> 16;
    r.slant_delay = (d > 64'd16777215) ? tsd_pkg::DELAY_MAX : d[23:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [24:0] random_elevation();
    case ($urandom_range(0, 9))
      7: return 25'($urandom);
      8: return 25'($urandom_range(0, 2000));
      9: return 25'($urandom_range(26352589, 26354589));
      default: return 25'($urandom_range(0, 26353589));
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls, long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 0;
        hold_cycles--;
      end else if (quiet) begin
        out_ch.ready <= 1;
      end else if (stall > 0) begin
        out_ch.ready <= 0;
        stall--;
      end else begin
        out_ch.ready <= 1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    delay_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = expected_results.pop_front();
        beats_checked++;
        if (out_ch.slant_delay !== e.slant_delay) begin
          $error("slant_delay expected %0d got %0d", e.slant_delay, out_ch.slant_delay);
          errors++;
        end
        if (out_ch.dry_mapping !== e.dry_mapping) begin
          $error("dry_mapping expected %0d got %0d", e.dry_mapping, out_ch.dry_mapping);
          errors++;
        end
        if (out_ch.wet_mapping !== e.wet_mapping) begin
          $error("wet_mapping expected %0d got %0d", e.wet_mapping, out_ch.wet_mapping);
          errors++;
        end
      end
    end
  end

  task automatic send_elevation(input logic [24:0] e, input bit typed, input delay_result_t k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1;
    in_ch.elevation <= e;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(typed ? k : predict_delay(e));
    beats_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (tsd_pkg::LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [21:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      tsd_pkg::REG_DRY_ZD: dry_zd = v[17:0];
      tsd_pkg::REG_WET_ZD: wet_zd = v[17:0];
      tsd_pkg::REG_DRY_OFF: dry_off = v;
      default: wet_off = v;
    endcase
  endtask

  task automatic load_setting(input logic [17:0] dz, input logic [17:0] wz,
                              input logic [21:0] doff, input logic [21:0] woff);
    drain();
    write_reg(tsd_pkg::REG_DRY_ZD, 22'(dz));
    write_reg(tsd_pkg::REG_WET_ZD, 22'(wz));
    write_reg(tsd_pkg::REG_DRY_OFF, doff);
    write_reg(tsd_pkg::REG_WET_OFF, woff);
    settings_run++;
  endtask

  task automatic run_random(input int n);
    delay_result_t none;
    none = '0;
    for (int i = 0; i < n; i++) send_elevation(random_elevation(), 0, none);
  endtask

  elev_row_t directed[$];
  localparam delay_result_t ALL_SAT = '{tsd_pkg::DELAY_MAX, tsd_pkg::MAP_MAX,
                                        tsd_pkg::MAP_MAX};

  task automatic run_directed(input bit use_typed);
    foreach (directed[i])
      send_elevation(directed[i].elevation, use_typed && directed[i].typed,
                     directed[i].known);
  endtask

  initial begin
    errors = 0; beats_sent = 0; beats_checked = 0; settings_run = 1;
    quiet = 0; hold_cycles = 0;
    rst_n = 0;
    cfg_we = 0; cfg_index = tsd_pkg::REG_DRY_ZD; cfg_wdata = '0;
    in_ch.valid = 0; in_ch.elevation = '0;
    dry_zd = 18'd150881; wet_zd = 18'd6605;
    dry_off = 22'd732044; wet_off = 22'd439226;

    // zero angle with zero offsets: sine vanishes, everything saturates
    directed = '{
      '{25'd0, 1, ALL_SAT},
      '{25'd1, 0, '0},
      '{25'd64, 0, '0},
      '{25'd2000, 0, '0},
      '{25'd175000, 0, '0},
      '{25'd732044, 0, '0},
      '{25'd2928140, 0, '0},
      '{25'd8784705, 0, '0},
      '{25'd13176795, 0, '0},
      '{25'd26353588, 0, '0},
      '{25'd26353589, 0, '0},
      '{25'd26353590, 0, '0},
      '{25'd30000000, 0, '0},
      '{25'h1555555, 0, '0},
      '{25'h0AAAAAA, 0, '0},
      '{25'h1FFFFFF, 0, '0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // defaults after reset
    run_directed(0);
    run_random(90);

    // largest delays, zero offsets
    load_setting(18'h3FFFF, 18'h3FFFF, 22'd0, 22'd0);
    run_directed(1);
    run_random(60);

    // zero delays, offsets of 2928140
    load_setting(18'd0, 18'd0, 22'd2928140, 22'd2928140);
    run_directed(0);
    run_random(60);

    // long hold-off on the result side while beats keep coming
    load_setting(18'($urandom), 18'($urandom), 22'($urandom_range(0, 2928140)),
                 22'($urandom_range(0, 2928140)));
    hold_cycles = 300;
    run_random(120);
    drain();  // sender waits for every result
    run_random(40);

    // back-to-back stretch with no idling
    load_setting(18'($urandom), 18'($urandom), 22'($urandom_range(0, 2928140)),
                 22'($urandom_range(0, 2928140)));
    quiet = 1;
    run_random(100);
    quiet = 0;

    load_setting(18'd150881, 18'd6605, 22'd732044, 22'd439226);
    run_random(100);

    drain();
    $display("covered %0d elevation beats, %0d results checked, %0d register settings",
             beats_sent, beats_checked, settings_run);
    $display("including saturation, fold past a right angle and a full result stall");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tsd_pkg.sv
rtl/tsd_if.sv
rtl/tsd_sqrt_cell.sv
rtl/tsd_cordic_cell.sv
rtl/tsd_div_cell.sv
rtl/tropo_slant_delay_unit.sv
sim/testbench.sv
